// ===== hdl/cau_pkg.sv =====
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

endpackage

// ===== hdl/complex_arithmetic_unit.sv =====
// Pipelined complex add/sub/mul/div in signed fixed point with saturation.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+------------------------------
//  input    | in_action, in_a_real/imag, in_b_real/imag    | beat when start && !busy
//  result   | out_res_real/imag, out_div_by_zero,          | beat when out_valid (1 cycle)
//           | out_overflowed                               |
//
// One beat may enter every cycle while busy is low; results leave in the order of their
// input beats. The divider gives one quotient bit per stage over DATA_WIDTH stages,
// behind four front stages (products, sums, magnitudes, setup) and followed by the
// output register. All actions take the same path, so ordering is kept.
// busy is high only while rst_n is low; reset clears the valid bits of all stages.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic signed [DATA_WIDTH-1:0] in_a_real,
  input  logic signed [DATA_WIDTH-1:0] in_a_imag,
  input  logic signed [DATA_WIDTH-1:0] in_b_real,
  input  logic signed [DATA_WIDTH-1:0] in_b_imag,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_real,
  output logic signed [DATA_WIDTH-1:0] out_res_imag,
  output logic                         out_div_by_zero,
  output logic                         out_overflowed
);

  localparam int DW = DATA_WIDTH;
  localparam int SW = DW + 1;
  localparam int W2 = 2 * DW;
  localparam int NW = W2 + 1 + FRACTION_BITS;
  localparam int CW = NW + DW;
  localparam logic [W2:0]   LIM_NEG = (W2+1)'(1) << (DW - 1);
  localparam logic [W2:0]   LIM_POS = LIM_NEG - (W2+1)'(1);
  localparam logic [DW-1:0] TOP_Q   = DW'(1) << (DW - 1);

  typedef struct packed {
    logic [W2-1:0] rem;
    logic [DW-1:0] q;
    logic [DW-1:0] nlo;
    logic          neg;
    logic          sat;
  } lane_t;

  // setup: divide lanes get remainder and overflow precheck (all zero on a zero divisor), others their final magnitude
  function automatic lane_t lane_prep(logic neg, logic [W2:0] mag, logic [W2-1:0] den,
                                      logic [1:0] act, logic dz);
    lane_t         l;
    logic [NW-1:0] n;
    logic [W2:0]   m;
    logic [W2:0]   lim;
    l   = '0;
    n   = NW'(mag) << FRACTION_BITS;
    m   = (act == ACT_MUL) ? (mag >> FRACTION_BITS) : mag;
    lim = (neg && (m != '0)) ? LIM_NEG : LIM_POS;
    if (dz) begin
      l = '0;
    end else if (act == ACT_DIV) begin
      // quotient needs more than DW bits exactly when n >= den * 2^DW
      l.sat = CW'(n) >= (CW'(den) << DW);
      l.rem = W2'(n >> DW);
      l.nlo = n[DW-1:0];
      l.neg = neg;
    end else begin
      l.sat = m > lim;
      l.q   = m[DW-1:0];
      l.neg = neg && (m != '0);
    end
    return l;
  endfunction

  // one restoring-division step
  function automatic lane_t lane_step(lane_t l, logic [W2-1:0] den);
    lane_t       o;
    logic [W2:0] sh;
    logic        ge;
    o     = l;
    sh    = {l.rem, l.nlo[DW-1]};
    ge    = sh >= {1'b0, den};
    o.rem = ge ? W2'(sh - {1'b0, den}) : W2'(sh);
    o.q   = {l.q[DW-2:0], ge};
    o.nlo = {l.nlo[DW-2:0], 1'b0};
    return o;
  endfunction

  // clamp and sign; returns {overflow, value}
  function automatic logic [DW:0] lane_out(lane_t l);
    logic [DW-1:0] lim;
    logic [DW-1:0] mag;
    logic          over;
    lim  = l.neg ? TOP_Q : TOP_Q - DW'(1);
    over = l.sat || (l.q > lim);
    mag  = over ? lim : l.q;
    return {over, l.neg ? (~mag) + DW'(1) : mag};
  endfunction

  logic accept;
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // stage 1: products and sums
  logic                 vld1_r;
  logic [1:0]           act1_r;
  logic signed [W2-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [SW-1:0] sum_re_r, sum_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    act1_r <= in_action;
    p_rr_r <= W2'(in_a_real) * W2'(in_b_real);
    p_ii_r <= W2'(in_a_imag) * W2'(in_b_imag);
    p_ri_r <= W2'(in_a_real) * W2'(in_b_imag);
    p_ir_r <= W2'(in_a_imag) * W2'(in_b_real);
    p_bb_r <= W2'(in_b_real) * W2'(in_b_real);
    p_cc_r <= W2'(in_b_imag) * W2'(in_b_imag);
    if (in_action == ACT_SUB) begin
      sum_re_r <= SW'(in_a_real) - SW'(in_b_real);
      sum_im_r <= SW'(in_a_imag) - SW'(in_b_imag);
    end else begin
      sum_re_r <= SW'(in_a_real) + SW'(in_b_real);
      sum_im_r <= SW'(in_a_imag) + SW'(in_b_imag);
    end
  end

  // stage 2: combine products, or pass the sums through for add and subtract
  logic               vld2_r;
  logic [1:0]         act2_r;
  logic signed [W2:0] re2_r, im2_r;
  logic [W2-1:0]      den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    act2_r <= act1_r;
    den2_r <= $unsigned(p_bb_r) + $unsigned(p_cc_r);
    unique case (act1_r)
      ACT_MUL: begin
        re2_r <= (W2+1)'(p_rr_r) - (W2+1)'(p_ii_r);
        im2_r <= (W2+1)'(p_ri_r) + (W2+1)'(p_ir_r);
      end
      ACT_DIV: begin
        re2_r <= (W2+1)'(p_rr_r) + (W2+1)'(p_ii_r);
        im2_r <= (W2+1)'(p_ir_r) - (W2+1)'(p_ri_r);
      end
      default: begin
        re2_r <= (W2+1)'(sum_re_r);
        im2_r <= (W2+1)'(sum_im_r);
      end
    endcase
  end

  // stage 3: sign and magnitude
  logic          vld3_r, dz3_r, neg_re3_r, neg_im3_r;
  logic [1:0]    act3_r;
  logic [W2:0]   mag_re3_r, mag_im3_r;
  logic [W2-1:0] den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    act3_r    <= act2_r;
    den3_r    <= den2_r;
    dz3_r     <= (act2_r == ACT_DIV) && (den2_r == '0);
    neg_re3_r <= re2_r[W2];
    neg_im3_r <= im2_r[W2];
    mag_re3_r <= re2_r[W2] ? $unsigned(-re2_r) : $unsigned(re2_r);
    mag_im3_r <= im2_r[W2] ? $unsigned(-im2_r) : $unsigned(im2_r);
  end

  // stage 4 (index 0) and divider stages 1..DW
  lane_t         re_r  [0:DW];
  lane_t         im_r  [0:DW];
  logic [W2-1:0] den_r [0:DW];
  logic          byp_r [0:DW];
  logic          dz_r  [0:DW];
  logic          vld_r [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    re_r[0]  <= lane_prep(neg_re3_r, mag_re3_r, den3_r, act3_r, dz3_r);
    im_r[0]  <= lane_prep(neg_im3_r, mag_im3_r, den3_r, act3_r, dz3_r);
    den_r[0] <= den3_r;
    byp_r[0] <= dz3_r || (act3_r != ACT_DIV);
    dz_r[0]  <= dz3_r;
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      re_r[k+1]  <= byp_r[k] ? re_r[k] : lane_step(re_r[k], den_r[k]);
      im_r[k+1]  <= byp_r[k] ? im_r[k] : lane_step(im_r[k], den_r[k]);
      den_r[k+1] <= den_r[k];
      byp_r[k+1] <= byp_r[k];
      dz_r[k+1]  <= dz_r[k];
    end
  end

  // output register
  logic          out_valid_r, out_dz_r, out_ovf_r;
  logic [DW-1:0] out_re_r, out_im_r;
  logic [DW:0]   fin_re, fin_im;

  assign fin_re = lane_out(re_r[DW]);
  assign fin_im = lane_out(im_r[DW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    out_re_r  <= fin_re[DW-1:0];
    out_im_r  <= fin_im[DW-1:0];
    out_dz_r  <= dz_r[DW];
    out_ovf_r <= fin_re[DW] || fin_im[DW];
  end

  assign out_valid       = out_valid_r;
  assign out_res_real    = out_re_r;
  assign out_res_imag    = out_im_r;
  assign out_div_by_zero = out_dz_r;
  assign out_overflowed  = out_ovf_r;

endmodule

// ===== hdl/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [1:0]            in_action,
  input logic                  out_valid,
  input logic [DATA_WIDTH-1:0] out_res_real,
  input logic [DATA_WIDTH-1:0] out_res_imag,
  input logic                  out_div_by_zero,
  input logic                  out_overflowed
);

  localparam int LAT = DATA_WIDTH + 5;

  // every result beat comes from an input beat a fixed latency earlier
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without matching input beat");

  a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |->
      out_res_real == '0 && out_res_imag == '0 && !out_overflowed)
    else $error("divide by zero gave nonzero result or overflow");

  a_dz_only_divide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> $past(in_action, LAT) == ACT_DIV)
    else $error("divide-by-zero flag on a non-divide beat");

  a_busy_in_reset: assert property (@(posedge clk)
    rst_n |-> !busy)
    else $error("busy outside reset");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_action      (in_action),
  .out_valid      (out_valid),
  .out_res_real   (out_res_real),
  .out_res_imag   (out_res_imag),
  .out_div_by_zero(out_div_by_zero),
  .out_overflowed (out_overflowed)
);

// ===== test/tb.sv =====
// Self-checking testbench for complex_arithmetic_unit: directed and random beats.
module tb;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = DW + 5;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 dz;
    logic                 ovf;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = ACT_ADD;
  logic signed [DW-1:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic out_valid;
  logic signed [DW-1:0] out_res_real, out_res_imag;
  logic out_div_by_zero, out_overflowed;

  cplx_result_t pending_results[$];
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int div_zero_seen = 0;
  int sat_seen = 0;

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRACTION_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_a_real(in_a_real), .in_a_imag(in_a_imag),
    .in_b_real(in_b_real), .in_b_imag(in_b_imag),
    .out_valid(out_valid), .out_res_real(out_res_real), .out_res_imag(out_res_imag),
    .out_div_by_zero(out_div_by_zero), .out_overflowed(out_overflowed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // clamp an exact value to the signed result width
  function automatic logic signed [DW-1:0] clamp_part(input logic signed [127:0] v,
                                                      inout logic ovf);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (DW-1)) - 128'sd1;
    lo = -(128'sd1 <<< (DW-1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // truncate toward zero after scaling down or dividing
  function automatic logic signed [127:0] scale_down(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [127:0] frac_div(input logic signed [127:0] num,
                                                   input logic signed [127:0] den);
    logic signed [127:0] m;
    m = (num < 0) ? -num : num;
    m = (m <<< FB) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic cplx_result_t complex_op(input logic [1:0] act,
      input logic signed [DW-1:0] ar, ai, br, bi);
    cplx_result_t r;
    logic signed [127:0] xr, xi, yr, yi, re, im, den;
    xr = 128'(ar); xi = 128'(ai); yr = 128'(br); yi = 128'(bi);
    r.dz = 1'b0;
    r.ovf = 1'b0;
    case (act)
      ACT_ADD: begin re = xr + yr; im = xi + yi; end
      ACT_SUB: begin re = xr - yr; im = xi - yi; end
      ACT_MUL: begin
        re = scale_down(xr * yr - xi * yi);
        im = scale_down(xr * yi + xi * yr);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == '0) begin
          r.dz = 1'b1; re = '0; im = '0;
        end else begin
          re = frac_div(xr * yr + xi * yi, den);
          im = frac_div(xi * yr - xr * yi, den);
        end
      end
    endcase
    r.re = clamp_part(re, r.ovf);
    r.im = clamp_part(im, r.ovf);
    return r;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 60);
  endfunction

  // send one beat; gap cycles of idle follow it
  task automatic send_beat(input logic [1:0] act, input logic signed [DW-1:0] ar, ai, br, bi,
                           input int gap);
    start <= 1'b1;
    in_action <= act;
    in_a_real <= ar; in_a_imag <= ai; in_b_real <= br; in_b_imag <= bi;
    do @(posedge clk); while (busy);
    pending_results.push_back(complex_op(act, ar, ai, br, bi));
    beats_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [DW-1:0] rand_operand(input int style);
    logic signed [DW-1:0] v;
    case (style)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: v = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      3: v = ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: v = '0;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic signed [DW-1:0] mx, mn, one;
    mx = 32'sh7fff_ffff; mn = 32'sh8000_0000; one = 32'sh0001_0000;
    for (int a = 0; a < 4; a++) begin
      send_beat(a[1:0], one, -one, one + one, one, 0);
      send_beat(a[1:0], mx, mx, mx, mx, 0);
      send_beat(a[1:0], mn, mn, mn, mn, 1);
      send_beat(a[1:0], mx, mn, mn, mx, 0);
      send_beat(a[1:0], '0, '0, '0, '0, 2);
    end
    // zero divisor with nonzero dividend, tiny divisors, and tiny products
    send_beat(ACT_DIV, mx, mn, '0, '0, 0);
    send_beat(ACT_DIV, mx, mx, 32'sd1, '0, 0);
    send_beat(ACT_DIV, one, one, '0, -32'sd1, 0);
    send_beat(ACT_MUL, 32'sd1, 32'sd1, 32'sd1, -32'sd1, 0);
    send_beat(ACT_MUL, -32'sd1, '0, 32'sd3, '0, 3);
  endtask

  task automatic test_random(input int count);
    logic [1:0] act;
    int sa, sb;
    logic signed [DW-1:0] br, bi;
    for (int n = 0; n < count; n++) begin
      act = 2'($urandom_range(0, 3));
      sa = $urandom_range(0, 9); sb = $urandom_range(0, 9);
      sa = (sa < 4) ? 0 : (sa < 6) ? 1 : (sa < 8) ? 2 : (sa < 9) ? 3 : 4;
      sb = (sb < 4) ? 0 : (sb < 6) ? 1 : (sb < 8) ? 2 : (sb < 9) ? 3 : 4;
      br = rand_operand(sb);
      bi = rand_operand(sb);
      if (act == ACT_DIV && $urandom_range(0, 15) == 0) begin
        br = '0; bi = '0;
      end
      send_beat(act, rand_operand(sa), rand_operand(sa), br, bi,
                ($urandom_range(0, 7) == 0) ? 0 : idle_len());
    end
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    cplx_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, out_res_real, out_res_imag);
        errors++;
      end else begin
        e = pending_results.pop_front();
        results_seen++;
        if (e.dz) div_zero_seen++;
        if (e.ovf) sat_seen++;
        if (out_res_real !== e.re || out_res_imag !== e.im ||
            out_div_by_zero !== e.dz || out_overflowed !== e.ovf) begin
          $display("%0t: expected re=%h im=%h dz=%b ovf=%b, got re=%h im=%h dz=%b ovf=%b",
                   $time, e.re, e.im, e.dz, e.ovf, out_res_real, out_res_imag,
                   out_div_by_zero, out_overflowed);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("complex_arithmetic_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1100);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("beats %0d, results %0d, zero divisors %0d, saturated %0d",
             beats_sent, results_seen, div_zero_seen, sat_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("complex_arithmetic_unit: match");
    else
      $display("complex_arithmetic_unit: mismatch");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/cau_pkg.sv
hdl/complex_arithmetic_unit.sv
hdl/cau_checker.sv
test/tb.sv
